>>> src/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, disabled while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> src/ght_pkg.sv
// Shared types and constants for the generational handle table.
package ght_pkg;

  localparam int unsigned SLOTS    = 1024;
  localparam int unsigned GEN_BITS = 32;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);

  localparam int unsigned PORT_IDX_W = 10;
  localparam int unsigned PORT_GEN_W = 32;
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned PORT_CNT_W = 11;

  typedef enum logic [1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_UNREGISTER = 2'd1,
    MODE_RESOLVE    = 2'd2,
    MODE_QUERY      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_STALE   = 3'd3,
    ST_FULL    = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [PORT_IDX_W-1:0] idx;
    logic [PORT_GEN_W-1:0] hgen;
    logic [TAG_W-1:0]      tag;
  } item_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [GEN_BITS-1:0] gen;
  } slot_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
  } stk_t;

  typedef struct packed {
    logic [CNT_W-1:0] free_top;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] live;
  } cnt_t;

  typedef struct packed {
    status_e               status;
    logic [PORT_IDX_W-1:0] index;
    logic [PORT_GEN_W-1:0] gen;
    logic [TAG_W-1:0]      tag;
  } res_t;

  typedef struct packed {
    logic             slot_we;
    logic [IDX_W-1:0] slot_addr;
    slot_t            slot_data;
    logic             stk_we;
    logic [IDX_W-1:0] stk_addr;
    stk_t             stk_data;
  } wr_t;

endpackage

>>> src/ght_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ght_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ght_exec.sv
// Command decode and slot/stack update logic for one transaction.
module ght_exec (
  input  ght_pkg::item_t item_i,
  input  ght_pkg::slot_t slot_i,
  input  ght_pkg::stk_t  top_i,
  input  ght_pkg::cnt_t  cnt_i,
  output ght_pkg::res_t  res_o,
  output ght_pkg::wr_t   wr_o,
  output ght_pkg::cnt_t  cnt_o
);
  import ght_pkg::*;

  logic                in_range;
  logic                gen_match;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] gen_next;
  logic [IDX_W-1:0]    item_addr;

  assign in_range  = 32'(item_i.idx) < 32'(cnt_i.used);
  assign gen_match = 32'(slot_i.gen) == 32'(item_i.hgen);
  assign gen_inc   = slot_i.gen + GEN_BITS'(1);
  assign gen_next  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign item_addr = IDX_W'(item_i.idx);

  always_comb begin
    logic [IDX_W-1:0]    alloc_idx;
    logic [GEN_BITS-1:0] alloc_gen;
    logic                got;

    alloc_idx      = '0;
    alloc_gen      = '0;
    got            = 1'b0;
    res_o.status   = ST_OK;
    res_o.index    = item_i.idx;
    res_o.gen      = '0;
    res_o.tag      = '0;
    wr_o           = '0;
    cnt_o          = cnt_i;

    unique case (mode_e'(item_i.mode))
      MODE_REGISTER: begin
        if (item_i.tag == '0) begin
          res_o.status = ST_NULL;
        end else if (cnt_i.free_top != '0) begin
          got            = 1'b1;
          alloc_idx      = top_i.idx;
          alloc_gen      = top_i.gen;
          cnt_o.free_top = cnt_i.free_top - CNT_W'(1);
        end else if (cnt_i.used < CNT_W'(SLOTS)) begin
          got        = 1'b1;
          alloc_idx  = IDX_W'(cnt_i.used);
          alloc_gen  = GEN_BITS'(1);
          cnt_o.used = cnt_i.used + CNT_W'(1);
        end else begin
          res_o.status = ST_FULL;
        end
        if (got) begin
          wr_o.slot_we       = 1'b1;
          wr_o.slot_addr     = alloc_idx;
          wr_o.slot_data.tag = item_i.tag;
          wr_o.slot_data.gen = alloc_gen;
          cnt_o.live         = cnt_i.live + CNT_W'(1);
          res_o.index        = PORT_IDX_W'(alloc_idx);
          res_o.gen          = PORT_GEN_W'(alloc_gen);
        end
      end
      MODE_UNREGISTER: begin
        if (item_i.tag == '0) begin
          res_o.status = ST_NULL;
        end else if (!in_range) begin
          res_o.status = ST_RANGE;
        end else if (slot_i.tag != item_i.tag || !gen_match) begin
          res_o.status = ST_STALE;
        end else begin
          wr_o.slot_we       = 1'b1;
          wr_o.slot_addr     = item_addr;
          wr_o.slot_data.tag = '0;
          wr_o.slot_data.gen = gen_next;
          if (cnt_i.free_top < CNT_W'(SLOTS)) begin
            wr_o.stk_we       = 1'b1;
            wr_o.stk_addr     = IDX_W'(cnt_i.free_top);
            wr_o.stk_data.idx = item_addr;
            wr_o.stk_data.gen = gen_next;
            cnt_o.free_top    = cnt_i.free_top + CNT_W'(1);
          end
          if (cnt_i.live != '0) begin
            cnt_o.live = cnt_i.live - CNT_W'(1);
          end
        end
      end
      MODE_RESOLVE: begin
        if (item_i.hgen == '0) begin
          res_o.status = ST_INVALID;
        end else if (!in_range) begin
          res_o.status = ST_RANGE;
        end else if (slot_i.tag == '0 || !gen_match) begin
          res_o.status = ST_STALE;
        end else begin
          res_o.tag = slot_i.tag;
        end
      end
      MODE_QUERY: begin
        if (!in_range) begin
          res_o.status = ST_RANGE;
        end else begin
          res_o.gen = PORT_GEN_W'(slot_i.gen);
        end
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase
  end

endmodule

>>> src/generational_handle_table.sv
// Generational handle table: slot allocator with free stack and generation checks.
// Inputs are registered in the execute stage (b_item_q), results in the output register.
// Throughput: one transaction per cycle unless a result is held by out_ready_i low; the slot
// RAM read and write-back with a one-deep forward from the last write-back set this figure.
// Reset clears counters and valid flags only; RAM contents are not cleared.
`include "assert_macros.svh"

module generational_handle_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic [ght_pkg::PORT_IDX_W-1:0]  slot_index_i,
  input  logic [ght_pkg::PORT_GEN_W-1:0]  handle_generation_i,
  input  logic [ght_pkg::TAG_W-1:0]       object_tag_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [ght_pkg::PORT_IDX_W-1:0]  index_out_o,
  output logic [ght_pkg::PORT_GEN_W-1:0]  generation_out_o,
  output logic [ght_pkg::TAG_W-1:0]       tag_out_o,
  output logic [ght_pkg::PORT_CNT_W-1:0]  live_count_o,
  output logic [ght_pkg::PORT_CNT_W-1:0]  slots_used_o
);
  import ght_pkg::*;

  logic             in_acc;
  logic             b_fire;
  logic             b_valid_q;
  item_t            b_item_q;
  cnt_t             cnt_q;
  cnt_t             cnt_d;
  cnt_t             exec_cnt;
  res_t             exec_res;
  wr_t              wr;
  logic [IDX_W-1:0] slot_raddr;
  logic [CNT_W-1:0] stk_rd_ptr;
  logic [IDX_W-1:0] stk_raddr;
  logic [$bits(slot_t)-1:0] slot_rdata;
  logic [$bits(stk_t)-1:0]  stk_rdata;
  slot_t            slot_cur;
  stk_t             stk_cur;
  logic             slot_fwd_valid_q;
  slot_t            slot_fwd_q;
  logic             stk_fwd_valid_q;
  stk_t             stk_fwd_q;
  logic             out_valid_q;
  res_t             res_q;
  logic [PORT_CNT_W-1:0] live_q;
  logic [PORT_CNT_W-1:0] used_q;

  assign b_fire     = b_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~b_valid_q | b_fire;
  assign in_acc     = in_valid_i & in_ready_o;

  assign cnt_d      = b_fire ? exec_cnt : cnt_q;
  assign slot_raddr = IDX_W'(slot_index_i);
  assign stk_rd_ptr = cnt_d.free_top - CNT_W'(1);
  assign stk_raddr  = stk_rd_ptr[IDX_W-1:0];

  ght_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire & wr.slot_we),
    .waddr_i (wr.slot_addr),
    .wdata_i (wr.slot_data),
    .re_i    (in_acc),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ght_ram #(
    .WIDTH ($bits(stk_t)),
    .DEPTH (SLOTS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire & wr.stk_we),
    .waddr_i (wr.stk_addr),
    .wdata_i (wr.stk_data),
    .re_i    (in_acc),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign slot_cur = slot_fwd_valid_q ? slot_fwd_q : slot_t'(slot_rdata);
  assign stk_cur  = stk_fwd_valid_q ? stk_fwd_q : stk_t'(stk_rdata);

  ght_exec u_exec (
    .item_i (b_item_q),
    .slot_i (slot_cur),
    .top_i  (stk_cur),
    .cnt_i  (cnt_q),
    .res_o  (exec_res),
    .wr_o   (wr),
    .cnt_o  (exec_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q        <= 1'b0;
      cnt_q            <= '0;
      slot_fwd_valid_q <= 1'b0;
      stk_fwd_valid_q  <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        b_valid_q        <= 1'b1;
        slot_fwd_valid_q <= b_fire & wr.slot_we & (wr.slot_addr == slot_raddr);
        stk_fwd_valid_q  <= b_fire & wr.stk_we & (wr.stk_addr == stk_raddr);
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_item_q.mode <= mode_i;
      b_item_q.idx  <= slot_index_i;
      b_item_q.hgen <= handle_generation_i;
      b_item_q.tag  <= object_tag_i;
      slot_fwd_q    <= wr.slot_data;
      stk_fwd_q     <= wr.stk_data;
    end
    if (b_fire) begin
      res_q  <= exec_res;
      live_q <= PORT_CNT_W'(exec_cnt.live);
      used_q <= PORT_CNT_W'(exec_cnt.used);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign index_out_o      = res_q.index;
  assign generation_out_o = res_q.gen;
  assign tag_out_o        = res_q.tag;
  assign live_count_o     = live_q;
  assign slots_used_o     = used_q;

  `ASSERT_CLK(a_slot_balance,
    32'(cnt_q.free_top) + 32'(cnt_q.live) == 32'(cnt_q.used),
    "free stack depth plus live count differs from slots used")
  `ASSERT_NEVER(a_used_bound, 32'(cnt_q.used) > 32'(SLOTS),
    "slots used exceeds table size")
  `ASSERT_CLK(a_stall_cause, !in_ready_o |-> (b_valid_q && out_valid_q && !out_ready_i),
    "input stalled without a blocked result")
  `ASSERT_CLK(a_fire_result, b_fire |=> out_valid_o,
    "executed transaction produced no result")

endmodule
